[rtl/accel_position_integrator_defines.svh]
`ifndef ACCEL_POSITION_INTEGRATOR_DEFINES_SVH
`define ACCEL_POSITION_INTEGRATOR_DEFINES_SVH

// Both macros expect clk_i and rst_ni in the scope where they are used.

// Same-cycle implication.
`define API_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define API_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/api_pkg.sv]
package api_pkg;

  localparam int ACC_W    = 16;
  localparam int POS_W    = 32;
  localparam int PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd655;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;
  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  // Datapath widths: d = acc - prev, m1 = d*p, dpp = d*p*p, vlp = vel[15:0]*p.
  localparam int D_W        = ACC_W + 1;
  localparam int M1_W       = D_W + PERIOD_W;
  localparam int DPP_W      = M1_W + PERIOD_W;
  localparam int VL_W       = 16;
  localparam int VLP_W      = VL_W + PERIOD_W;
  localparam int V_SHIFT    = 16;
  localparam int L_SHIFT    = 33;
  localparam int VLP_SHIFT  = L_SHIFT - V_SHIFT;
  localparam int L_W        = VLP_W + VLP_SHIFT + 2;

  localparam int STEP_W = 4;

  typedef enum logic [1:0] {
    MS_D,
    MS_PROD,
    MS_VL,
    MS_VH
  } mul_src_e;

  typedef enum logic [1:0] {
    LS_HOLD,
    LS_LOAD,
    LS_ADD
  } lsum_op_e;

  typedef enum logic [2:0] {
    BR_SEQ,
    BR_GOTO,
    BR_IF_CLR,
    BR_LOOP,
    BR_END
  } branch_e;

  typedef struct packed {
    mul_src_e            mul_src;
    logic                ld_prod;
    logic                ld_d;
    logic                wr_prev;
    logic                wr_vel;
    logic                ld_vold;
    lsum_op_e            lsum_op;
    logic                ld_psum;
    logic                wr_pos;
    logic                clr;
    branch_e             branch;
    logic [STEP_W-1:0]   target;
  } ucw_t;

  // Program addresses.
  localparam logic [STEP_W-1:0] ST_ENTRY    = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_LOAD_D   = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_MUL_D    = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_VEL      = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_LSUM_LD  = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_LSUM_ADD = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_PSUM     = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_POS      = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_DONE     = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_CLEAR    = STEP_W'(9);

  localparam ucw_t UCW_NOP = '{
    mul_src: MS_D,
    ld_prod: 1'b0,
    ld_d:    1'b0,
    wr_prev: 1'b0,
    wr_vel:  1'b0,
    ld_vold: 1'b0,
    lsum_op: LS_HOLD,
    ld_psum: 1'b0,
    wr_pos:  1'b0,
    clr:     1'b0,
    branch:  BR_END,
    target:  ST_DONE
  };

  // Control store. The axis loop runs from ST_LOAD_D to ST_POS once per axis.
  function automatic ucw_t api_ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = UCW_NOP;
    unique case (step)
      ST_ENTRY: begin
        w.branch = BR_IF_CLR;
        w.target = ST_CLEAR;
      end
      ST_LOAD_D: begin
        w.ld_d    = 1'b1;
        w.wr_prev = 1'b1;
        w.branch  = BR_SEQ;
      end
      ST_MUL_D: begin
        w.mul_src = MS_D;
        w.ld_prod = 1'b1;
        w.branch  = BR_SEQ;
      end
      ST_VEL: begin
        w.wr_vel  = 1'b1;
        w.ld_vold = 1'b1;
        w.mul_src = MS_PROD;
        w.ld_prod = 1'b1;
        w.branch  = BR_SEQ;
      end
      ST_LSUM_LD: begin
        w.lsum_op = LS_LOAD;
        w.mul_src = MS_VL;
        w.ld_prod = 1'b1;
        w.branch  = BR_SEQ;
      end
      ST_LSUM_ADD: begin
        w.lsum_op = LS_ADD;
        w.mul_src = MS_VH;
        w.ld_prod = 1'b1;
        w.branch  = BR_SEQ;
      end
      ST_PSUM: begin
        w.ld_psum = 1'b1;
        w.branch  = BR_SEQ;
      end
      ST_POS: begin
        w.wr_pos = 1'b1;
        w.branch = BR_LOOP;
        w.target = ST_LOAD_D;
      end
      ST_CLEAR: begin
        w.clr    = 1'b1;
        w.branch = BR_GOTO;
        w.target = ST_DONE;
      end
      default: begin
        w = UCW_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/api_if.sv]
interface api_in_if;
  import api_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] acc_z;
  modport source (output valid, req_type, acc_x, acc_y, acc_z, input ready);
  modport sink   (input valid, req_type, acc_x, acc_y, acc_z, output ready);
endinterface

interface api_out_if;
  import api_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface api_cfg_if;
  import api_pkg::*;
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] sample_period;
  modport source (output valid, sample_period, input ready);
  modport sink   (input valid, sample_period, output ready);
endinterface

[rtl/api_dpath.sv]
module api_dpath #(
  parameter int STATE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  api_pkg::ucw_t                     ctrl_i,
  input  logic [api_pkg::AXIS_W-1:0]        axis_i,
  input  logic                              load_i,
  input  logic signed [api_pkg::ACC_W-1:0]  acc_x_i,
  input  logic signed [api_pkg::ACC_W-1:0]  acc_y_i,
  input  logic signed [api_pkg::ACC_W-1:0]  acc_z_i,
  input  logic [api_pkg::PERIOD_W-1:0]      period_i,
  output logic signed [api_pkg::POS_W-1:0]  pos_x_o,
  output logic signed [api_pkg::POS_W-1:0]  pos_y_o,
  output logic signed [api_pkg::POS_W-1:0]  pos_z_o
);
  import api_pkg::*;

  localparam int SW    = STATE_WIDTH;
  localparam int VhW   = SW - VL_W;
  localparam int MulAW = (VhW > M1_W + 1) ? VhW : M1_W + 1;
  localparam int PW    = MulAW + PERIOD_W + 1;
  localparam int OW    = (SW > POS_W) ? SW : POS_W;

  logic signed [ACC_W-1:0]          acc_q  [NUM_AXES];
  logic signed [ACC_W-1:0]          prev_q [NUM_AXES];
  logic signed [SW-1:0]             vel_q  [NUM_AXES];
  logic signed [SW-1:0]             pos_q  [NUM_AXES];
  logic signed [POS_W-1:0]          pos_sat [NUM_AXES];

  logic signed [D_W-1:0]            d_q;
  logic signed [PW-1:0]             prod_q;
  logic signed [SW-1:0]             vold_q;
  logic signed [L_W-1:0]            lsum_q;
  logic signed [SW:0]               psum_q;

  logic signed [ACC_W-1:0]          acc_cur;
  logic signed [ACC_W-1:0]          prev_cur;
  logic signed [SW-1:0]             vel_cur;
  logic signed [SW-1:0]             pos_cur;

  logic signed [MulAW-1:0]          mul_a;
  logic signed [PERIOD_W:0]         mul_b;
  logic signed [PW-1:0]             mul_p;

  logic signed [M1_W-1:0]           m1;
  logic signed [M1_W-V_SHIFT-1:0]   vq;
  logic                             vfrac;
  logic signed [VhW-1:0]            vh;
  logic signed [SW-1:0]             vhp;
  logic signed [DPP_W-1:0]          dpp;
  logic [VLP_W-1:0]                 vlp;
  logic [SW:0]                      vsum;
  logic [SW:0]                      vtr;
  logic signed [SW-1:0]             vel_new;

  logic signed [L_W-L_SHIFT-1:0]    lq;
  logic                             lfrac;
  logic [SW+1:0]                    ptot;
  logic [SW+1:0]                    ptr;
  logic [2:0]                       ptop;
  logic signed [SW-1:0]             pos_new;

  assign acc_cur  = acc_q[axis_i];
  assign prev_cur = prev_q[axis_i];
  assign vel_cur  = vel_q[axis_i];
  assign pos_cur  = pos_q[axis_i];

  // Views of the product register for the different steps of the program.
  assign m1  = prod_q[M1_W-1:0];
  assign dpp = prod_q[DPP_W-1:0];
  assign vlp = prod_q[VLP_W-1:0];
  assign vhp = prod_q[SW-1:0];
  assign vh  = vold_q[SW-1:VL_W];

  always_comb begin
    unique case (ctrl_i.mul_src)
      MS_D:    mul_a = MulAW'(d_q);
      MS_PROD: mul_a = MulAW'(m1);
      MS_VL:   mul_a = MulAW'(vold_q[VL_W-1:0]);
      MS_VH:   mul_a = MulAW'(vh);
      default: mul_a = MulAW'(d_q);
    endcase
  end

  assign mul_b = {1'b0, period_i};
  assign mul_p = mul_a * mul_b;

  // Velocity: vel + d*p/2^16, truncated toward zero, then saturated.
  assign vq    = m1[M1_W-1:V_SHIFT];
  assign vfrac = |m1[V_SHIFT-1:0];
  assign vsum  = (SW+1)'(vel_cur) + (SW+1)'(vq);
  assign vtr   = vsum + (SW+1)'(vfrac & vsum[SW]);
  assign vel_new = (vtr[SW] != vtr[SW-1]) ? {vtr[SW], {(SW-1){~vtr[SW]}}}
                                          : vtr[SW-1:0];

  // Position: the low partial sum carries the fraction below 2^-33.
  assign lq    = lsum_q[L_W-1:L_SHIFT];
  assign lfrac = |lsum_q[L_SHIFT-1:0];
  assign ptot  = (SW+2)'(psum_q) + (SW+2)'(lq);
  assign ptr   = ptot + (SW+2)'(lfrac & ptot[SW+1]);
  assign ptop  = ptr[SW+1:SW-1];
  assign pos_new = (&ptop || ~|ptop) ? ptr[SW-1:0]
                                     : {ptr[SW+1], {(SW-1){~ptr[SW+1]}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_q[i] <= '0;
        vel_q[i]  <= '0;
        pos_q[i]  <= '0;
      end
    end else if (ctrl_i.clr) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_q[i] <= '0;
        vel_q[i]  <= '0;
        pos_q[i]  <= '0;
      end
    end else begin
      if (ctrl_i.wr_prev) begin
        prev_q[axis_i] <= acc_cur;
      end
      if (ctrl_i.wr_vel) begin
        vel_q[axis_i] <= vel_new;
      end
      if (ctrl_i.wr_pos) begin
        pos_q[axis_i] <= pos_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      acc_q[0] <= acc_x_i;
      acc_q[1] <= acc_y_i;
      acc_q[2] <= acc_z_i;
    end
    if (ctrl_i.ld_d) begin
      d_q <= D_W'(acc_cur) - D_W'(prev_cur);
    end
    if (ctrl_i.ld_prod) begin
      prod_q <= mul_p;
    end
    if (ctrl_i.ld_vold) begin
      vold_q <= vel_cur;
    end
    unique case (ctrl_i.lsum_op)
      LS_LOAD: lsum_q <= L_W'(dpp);
      LS_ADD:  lsum_q <= lsum_q + L_W'({vlp, {VLP_SHIFT{1'b0}}});
      default: lsum_q <= lsum_q;
    endcase
    if (ctrl_i.ld_psum) begin
      psum_q <= (SW+1)'(pos_cur) + (SW+1)'(vhp);
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_sat
    logic signed [OW-1:0]   pe;
    logic [OW-POS_W:0]      hi_bits;
    assign pe      = OW'(pos_q[g]);
    assign hi_bits = pe[OW-1:POS_W-1];
    assign pos_sat[g] = (&hi_bits || ~|hi_bits) ? pe[POS_W-1:0]
                                                : {pe[OW-1], {(POS_W-1){~pe[OW-1]}}};
  end

  assign pos_x_o = pos_sat[0];
  assign pos_y_o = pos_sat[1];
  assign pos_z_o = pos_sat[2];

endmodule

[rtl/accel_position_integrator.sv]
// Three-axis dead-reckoning integrator.
// Items arrive on in_i: req_type selects integrate (0) or clear (1), with one
// signed acceleration sample per axis. Each item yields exactly one result on
// out_o with the three saturated positions. cfg_i writes the sample period and
// is always ready; the user must write it only while the block is idle.
// The block does not enforce this. An integrate item runs a seven-step
// microprogram per axis on one shared 34x17 multiplier; its result becomes
// valid in the same cycle as in_i is ready again. A clear item skips the
// axis loop and gives an all-zero result.
// The result sits in an output register, so a new item is taken while the
// previous result waits. If the receiver still stalls when the next result is
// ready, the program holds on its last step and in_i stays low until the
// result register is free.
// Reset zeroes velocity, position and previous samples, restores the sample
// period to 655 and leaves both channels idle.
module accel_position_integrator #(
  parameter int STATE_WIDTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  api_cfg_if.sink    cfg_i,
  api_in_if.sink     in_i,
  api_out_if.source  out_o
);
  import api_pkg::*;

  logic                     running_q, running_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [AXIS_W-1:0]        axis_q, axis_d;
  logic                     clr_req_q;
  logic [PERIOD_W-1:0]      period_q;
  logic                     out_valid_q;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic signed [POS_W-1:0]  dp_pos_x, dp_pos_y, dp_pos_z;

  logic                     in_acc;
  logic                     out_load;
  ucw_t                     ucw;
  ucw_t                     dp_ctrl;

  assign in_i.ready  = !running_q;
  assign in_acc      = in_i.valid && !running_q;
  assign cfg_i.ready = 1'b1;

  assign ucw     = api_ucode(step_q);
  assign dp_ctrl = running_q ? ucw : UCW_NOP;

  always_comb begin
    running_d = running_q;
    step_d    = step_q;
    axis_d    = axis_q;
    out_load  = 1'b0;
    if (in_acc) begin
      running_d = 1'b1;
      step_d    = ST_ENTRY;
      axis_d    = '0;
    end else if (running_q) begin
      unique case (ucw.branch)
        BR_SEQ:    step_d = step_q + 1'b1;
        BR_GOTO:   step_d = ucw.target;
        BR_IF_CLR: step_d = clr_req_q ? ucw.target : step_q + 1'b1;
        BR_LOOP: begin
          if (axis_q == AXIS_LAST) begin
            step_d = step_q + 1'b1;
          end else begin
            axis_d = axis_q + 1'b1;
            step_d = ucw.target;
          end
        end
        BR_END: begin
          // Wait here until the result register can take the new positions.
          if (!out_valid_q || out_o.ready) begin
            out_load  = 1'b1;
            running_d = 1'b0;
          end
        end
        default: step_d = step_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      step_q      <= ST_DONE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      period_q    <= PERIOD_RESET;
    end else begin
      running_q <= running_d;
      step_q    <= step_d;
      axis_q    <= axis_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        period_q <= cfg_i.sample_period;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      clr_req_q <= in_i.req_type;
    end
    if (out_load) begin
      pos_x_q <= dp_pos_x;
      pos_y_q <= dp_pos_y;
      pos_z_q <= dp_pos_z;
    end
  end

  api_dpath #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (dp_ctrl),
    .axis_i   (axis_q),
    .load_i   (in_acc),
    .acc_x_i  (in_i.acc_x),
    .acc_y_i  (in_i.acc_y),
    .acc_z_i  (in_i.acc_z),
    .period_i (period_q),
    .pos_x_o  (dp_pos_x),
    .pos_y_o  (dp_pos_y),
    .pos_z_o  (dp_pos_z)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.pos_x = pos_x_q;
  assign out_o.pos_y = pos_y_q;
  assign out_o.pos_z = pos_z_q;

endmodule

[rtl/api_checker.sv]
`include "accel_position_integrator_defines.svh"

module api_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_req_type_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [api_pkg::POS_W-1:0] pos_x_i,
  input logic signed [api_pkg::POS_W-1:0] pos_y_i,
  input logic signed [api_pkg::POS_W-1:0] pos_z_i
);
  import api_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] cnt_q;
  logic [1:0] clr_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items taken but not yet answered, and which of them were clear requests.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      clr_q <= '0;
    end else if (in_acc && !out_acc) begin
      clr_q[cnt_q[0]] <= in_req_type_i;
      cnt_q           <= cnt_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      clr_q[0] <= clr_q[1];
      cnt_q    <= cnt_q - 1'b1;
    end else if (in_acc && out_acc) begin
      clr_q[0] <= in_req_type_i;
    end
  end

  `API_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready_i, "input taken while busy")
  `API_ASSERT_IMP(a_no_orphan_result, out_valid_i, cnt_q != 2'd0, "result without an item")
  `API_ASSERT_IMP(a_full_blocks_input, cnt_q == 2'd2, !in_ready_i, "third item in flight")
  `API_ASSERT_IMP(a_clear_gives_zero, out_valid_i && clr_q[0], (pos_x_i == '0) && (pos_y_i == '0) && (pos_z_i == '0), "clear result not zero")
  `API_ASSERT_NXT(a_stall_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(pos_x_i) && $stable(pos_y_i) && $stable(pos_z_i), "stalled result changed")

endmodule

bind accel_position_integrator api_checker u_api_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_req_type_i (in_i.req_type),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pos_x_i       (out_o.pos_x),
  .pos_y_i       (out_o.pos_y),
  .pos_z_i       (out_o.pos_z)
);
